/* hdl/lms_pkg.sv */
// Shared types and constants for the LED mode sequencer.
`default_nettype none

package lms_pkg;

    // Fixed widths of the tick counters, fade step, configuration data, configuration index and mode
    localparam int TICK_BITS    = 16;
    localparam int STEP_BITS    = 8;
    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int MODE_BITS    = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLINK_TICKS    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_TICKS     = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_STEP      = 2'd3;

    // Configuration reset values
    localparam logic [TICK_BITS-1:0] DEBOUNCE_TICKS_RST = 16'd30;
    localparam logic [TICK_BITS-1:0] BLINK_TICKS_RST    = 16'd500;
    localparam logic [TICK_BITS-1:0] FADE_TICKS_RST     = 16'd10;
    localparam logic [STEP_BITS-1:0] FADE_STEP_RST      = 8'd5;

    // LED modes, advanced in this order by the cycle button
    typedef enum logic [MODE_BITS-1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_BLINK = 2'd2,
        MODE_FADE  = 2'd3
    } mode_t;

endpackage

`default_nettype wire

/* hdl/lms_debounce.sv */
// Quiet-time debouncer for one active-low button, flags a stable press edge.
`default_nettype none

module lms_debounce
    import lms_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step_en,
    input  wire logic                 raw,
    input  wire logic [TICK_BITS-1:0] debounce_ticks,
    output logic                      fall_edge
);

    localparam int CmpBits = (COUNT_BITS > TICK_BITS) ? COUNT_BITS : TICK_BITS;

    logic                  prev_reg;
    logic                  prev_next;
    logic [COUNT_BITS-1:0] quiet_reg;
    logic [COUNT_BITS-1:0] quiet_next;
    logic                  stable_reg;
    logic                  stable_next;
    logic                  settle;

    // Restart the quiet count on a raw change, otherwise count up and saturate
    always_comb
    begin
        if (raw != prev_reg)
        begin
            quiet_next = '0;
        end
        else if (&quiet_reg)
        begin
            quiet_next = quiet_reg;
        end
        else
        begin
            quiet_next = quiet_reg + COUNT_BITS'(1);
        end
        prev_next   = raw;
        settle      = (CmpBits'(quiet_next) >= CmpBits'(debounce_ticks)) &&
                      (stable_reg != raw);
        stable_next = settle ? raw : stable_reg;
        fall_edge   = step_en && settle && stable_reg && !raw;
    end

    // Advance debounce state once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= 1'b1;
            quiet_reg  <= '0;
            stable_reg <= 1'b1;
        end
        else if (step_en)
        begin
            prev_reg   <= prev_next;
            quiet_reg  <= quiet_next;
            stable_reg <= stable_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/led_mode_sequencer_top.sv */
// Top level of the LED mode sequencer: debounce, mode control, blink and fade.
//
// channel  | direction | contents
// ---------+-----------+---------------------------------------------------
// s_axis   | in        | one tick request: cycle and reset raw button levels
// m_axis   | out       | one result per tick: three LED levels and the mode
// cfg      | in        | write-only register port, four registers
//
// A new request is accepted every cycle while no held result is stalled on m_axis.
// The result sits in a single output register; the next request is taken
// in the same cycle as the held result leaves, so rate is set by that register.
// Reset (rst_n low, asynchronous) restores register defaults and mode off.
// A stall on m_axis holds s_axis_tready low only while the result is not taken.
`default_nettype none

module led_mode_sequencer_top
    import lms_pkg::*;
#(
    parameter int  LEVEL_BITS = 8,
    parameter int  COUNT_BITS = 16,
    localparam int OutBits    = ((3 * LEVEL_BITS + MODE_BITS + 7) / 8) * 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // [0] cycle_button_raw, [1] reset_button_raw, rest zero
    input  wire logic [7:0]              s_axis_tdata,

    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // yellow_level, green_level, red_level, current_mode, zero fill
    output logic [OutBits-1:0]           m_axis_tdata,

    input  wire logic                    cfg_wen,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]     cfg_wdata
);

    localparam int CmpBits = (COUNT_BITS > TICK_BITS) ? COUNT_BITS : TICK_BITS;
    localparam int SumBits = ((LEVEL_BITS > STEP_BITS) ? LEVEL_BITS : STEP_BITS) + 1;
    localparam int PadBits = OutBits - 3 * LEVEL_BITS - MODE_BITS;
    localparam logic [LEVEL_BITS-1:0] LevelMax = '1;

    // Configuration registers
    logic [TICK_BITS-1:0] debounce_ticks_reg;
    logic [TICK_BITS-1:0] blink_ticks_reg;
    logic [TICK_BITS-1:0] fade_ticks_reg;
    logic [STEP_BITS-1:0] fade_step_reg;

    // Sequencer state
    mode_t                 mode_reg;
    mode_t                 mode_next;
    logic                  blink_phase_reg;
    logic                  blink_phase_next;
    logic [COUNT_BITS-1:0] blink_elapsed_reg;
    logic [COUNT_BITS-1:0] blink_elapsed_next;
    logic [LEVEL_BITS-1:0] fade_value_reg;
    logic [LEVEL_BITS-1:0] fade_value_next;
    logic                  fade_rising_reg;
    logic                  fade_rising_next;
    logic [COUNT_BITS-1:0] fade_elapsed_reg;
    logic [COUNT_BITS-1:0] fade_elapsed_next;
    logic [LEVEL_BITS-1:0] level_reg  [3];
    logic [LEVEL_BITS-1:0] level_next [3];

    // Result register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OutBits-1:0]    out_data_reg;

    logic                  in_fire;
    logic                  cycle_edge;
    logic                  reset_edge;
    logic                  any_edge;
    mode_t                 mode_stepped;
    logic [COUNT_BITS-1:0] blink_inc;
    logic [COUNT_BITS-1:0] fade_inc;
    logic [COUNT_BITS-1:0] blink_cur;
    logic [COUNT_BITS-1:0] fade_cur;
    logic [LEVEL_BITS-1:0] fade_val_cur;
    logic                  fade_rise_cur;
    logic [SumBits-1:0]    fade_sum;
    logic [SumBits-1:0]    fade_diff;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Debounce both buttons
    lms_debounce #(
        .COUNT_BITS (COUNT_BITS)
    ) u_cycle_deb (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (in_fire),
        .raw            (s_axis_tdata[0]),
        .debounce_ticks (debounce_ticks_reg),
        .fall_edge      (cycle_edge)
    );

    lms_debounce #(
        .COUNT_BITS (COUNT_BITS)
    ) u_reset_deb (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (in_fire),
        .raw            (s_axis_tdata[1]),
        .debounce_ticks (debounce_ticks_reg),
        .fall_edge      (reset_edge)
    );

    // Hold configuration, write on enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DEBOUNCE_TICKS_RST;
            blink_ticks_reg    <= BLINK_TICKS_RST;
            fade_ticks_reg     <= FADE_TICKS_RST;
            fade_step_reg      <= FADE_STEP_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_wdata[TICK_BITS-1:0];
                CFG_BLINK_TICKS:    blink_ticks_reg    <= cfg_wdata[TICK_BITS-1:0];
                CFG_FADE_TICKS:     fade_ticks_reg     <= cfg_wdata[TICK_BITS-1:0];
                CFG_FADE_STEP:      fade_step_reg      <= cfg_wdata[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Saturating elapsed counts, mode step and edge clearing
    always_comb
    begin
        blink_inc     = (&blink_elapsed_reg) ? blink_elapsed_reg
                                             : blink_elapsed_reg + COUNT_BITS'(1);
        fade_inc      = (&fade_elapsed_reg) ? fade_elapsed_reg
                                            : fade_elapsed_reg + COUNT_BITS'(1);
        any_edge      = cycle_edge || reset_edge;
        mode_stepped  = cycle_edge ? mode_t'(MODE_BITS'(mode_reg + 2'd1)) : mode_reg;
        blink_cur     = any_edge ? '0 : blink_inc;
        fade_cur      = any_edge ? '0 : fade_inc;
        fade_val_cur  = any_edge ? '0 : fade_value_reg;
        fade_rise_cur = any_edge ? 1'b1 : fade_rising_reg;
        fade_sum      = SumBits'(fade_val_cur) + SumBits'(fade_step_reg);
        fade_diff     = SumBits'(fade_val_cur) - SumBits'(fade_step_reg);
    end

    // Drive mode, blink, fade and levels for the current tick
    always_comb
    begin
        mode_next          = reset_edge ? MODE_OFF : mode_stepped;
        blink_phase_next   = any_edge ? 1'b0 : blink_phase_reg;
        blink_elapsed_next = blink_cur;
        fade_value_next    = fade_val_cur;
        fade_rising_next   = fade_rise_cur;
        fade_elapsed_next  = fade_cur;
        for (int i = 0; i < 3; i++)
        begin
            level_next[i] = reset_edge ? '0 : level_reg[i];
        end

        case (mode_next)
            MODE_OFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    level_next[i] = '0;
                end
            end
            MODE_ON:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    level_next[i] = LevelMax;
                end
            end
            MODE_BLINK:
            begin
                if (CmpBits'(blink_cur) >= CmpBits'(blink_ticks_reg))
                begin
                    blink_phase_next   = !blink_phase_next;
                    blink_elapsed_next = '0;
                end
                level_next[0] = blink_phase_next ? LevelMax : '0;
                level_next[1] = blink_phase_next ? '0 : LevelMax;
                level_next[2] = blink_phase_next ? LevelMax : '0;
            end
            default:
            begin
                if (CmpBits'(fade_cur) >= CmpBits'(fade_ticks_reg))
                begin
                    if (fade_rise_cur)
                    begin
                        if (fade_sum >= SumBits'(LevelMax))
                        begin
                            fade_value_next  = LevelMax;
                            fade_rising_next = 1'b0;
                        end
                        else
                        begin
                            // a zero step leaves the level where it is
                            fade_value_next = fade_sum[LEVEL_BITS-1:0];
                        end
                    end
                    else if (SumBits'(fade_val_cur) <= SumBits'(fade_step_reg))
                    begin
                        fade_value_next  = '0;
                        fade_rising_next = 1'b1;
                    end
                    else
                    begin
                        fade_value_next = fade_diff[LEVEL_BITS-1:0];
                    end
                    for (int i = 0; i < 3; i++)
                    begin
                        level_next[i] = fade_value_next;
                    end
                    fade_elapsed_next = '0;
                end
            end
        endcase
    end

    // Advance sequencer state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_OFF;
            blink_phase_reg   <= 1'b0;
            blink_elapsed_reg <= '0;
            fade_value_reg    <= '0;
            fade_rising_reg   <= 1'b1;
            fade_elapsed_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                level_reg[i] <= '0;
            end
        end
        else if (in_fire)
        begin
            mode_reg          <= mode_next;
            blink_phase_reg   <= blink_phase_next;
            blink_elapsed_reg <= blink_elapsed_next;
            fade_value_reg    <= fade_value_next;
            fade_rising_reg   <= fade_rising_next;
            fade_elapsed_reg  <= fade_elapsed_next;
            for (int i = 0; i < 3; i++)
            begin
                level_reg[i] <= level_next[i];
            end
        end
    end

    // Hold result until taken, load a new one on each accepted request
    always_comb
    begin
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= {{PadBits{1'b0}}, mode_next,
                             level_next[2], level_next[1], level_next[0]};
        end
    end

`ifndef SYNTHESIS
    // Off mode shows all LEDs dark
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg[3*LEVEL_BITS +: MODE_BITS] == MODE_OFF)
        |-> (out_data_reg[3*LEVEL_BITS-1:0] == '0))
        else $error("off mode result with nonzero level");

    // Blink mode drives the second channel opposite to the first and third
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg[3*LEVEL_BITS +: MODE_BITS] == MODE_BLINK)
        |-> (out_data_reg[LEVEL_BITS +: LEVEL_BITS] == ~out_data_reg[0 +: LEVEL_BITS])
            && (out_data_reg[2*LEVEL_BITS +: LEVEL_BITS] == out_data_reg[0 +: LEVEL_BITS]))
        else $error("blink levels not complementary");

    // Mode and fade state change only with an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(mode_reg) && $stable(fade_value_reg))
        else $error("sequencer state moved without a request");

    // A stalled input side means a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> out_valid_reg && !m_axis_tready)
        else $error("input stalled with no pending result");

    // A reset press always lands in off mode
    assert property (@(posedge clk) disable iff (!rst_n)
        reset_edge |=> (mode_reg == MODE_OFF) && (fade_value_reg == '0))
        else $error("reset press did not force off mode");
`endif

endmodule

`default_nettype wire

/* test/led_mode_sequencer_top_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the LED mode sequencer: directed button ticks, then random presses.

module led_mode_sequencer_top_test;
    import lms_pkg::*;

    localparam int OUT_BITS     = ((3 * 8 + MODE_BITS + 7) / 8) * 8;
    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 60;
    localparam int LEVEL_FULL   = 255;
    localparam int PHASES       = 8;

    // One result as it sits on m_axis_tdata, lowest field last
    typedef struct packed {
        logic [OUT_BITS-27:0] fill;
        mode_t                mode;
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           yellow;
    } led_levels_t;

    // Tracks debounce, mode, blink and fade state; holds the levels still owed
    class led_mode_tracker;
        logic [TICK_BITS-1:0] debounce_ticks;
        logic [TICK_BITS-1:0] blink_ticks;
        logic [TICK_BITS-1:0] fade_ticks;
        logic [STEP_BITS-1:0] fade_step;
        bit                   cyc_prev;
        bit                   cyc_stable;
        logic [TICK_BITS-1:0] cyc_quiet;
        bit                   rst_prev;
        bit                   rst_stable;
        logic [TICK_BITS-1:0] rst_quiet;
        mode_t                mode;
        bit                   blink_phase;
        logic [TICK_BITS-1:0] blink_elapsed;
        logic [TICK_BITS-1:0] fade_elapsed;
        int unsigned          fade_value;
        bit                   fade_rising;
        logic [7:0]           levels[3];
        led_levels_t          levels_due[$];
        int                   errors;

        function new();
            debounce_ticks = DEBOUNCE_TICKS_RST;
            blink_ticks    = BLINK_TICKS_RST;
            fade_ticks     = FADE_TICKS_RST;
            fade_step      = FADE_STEP_RST;
            cyc_prev       = 1'b1;
            cyc_stable     = 1'b1;
            cyc_quiet      = '0;
            rst_prev       = 1'b1;
            rst_stable     = 1'b1;
            rst_quiet      = '0;
            mode           = MODE_OFF;
            clear_effects();
            set_all(8'h00);
            errors         = 0;
        endfunction

        function void write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
            case (idx)
                CFG_DEBOUNCE_TICKS: debounce_ticks = value;
                CFG_BLINK_TICKS:    blink_ticks    = value;
                CFG_FADE_TICKS:     fade_ticks     = value;
                CFG_FADE_STEP:      fade_step      = value[STEP_BITS-1:0];
                default:            ;
            endcase
        endfunction

        function void clear_effects();
            fade_value    = 0;
            fade_rising   = 1'b1;
            blink_phase   = 1'b0;
            blink_elapsed = '0;
            fade_elapsed  = '0;
        endfunction

        function void set_all(logic [7:0] level);
            levels[0] = level;
            levels[1] = level;
            levels[2] = level;
        endfunction

        // Debounce one button; return 1 on an accepted press (released to pressed)
        function bit debounce(bit raw, inout bit prev, inout logic [TICK_BITS-1:0] quiet,
                              inout bit stable);
            bit fell = 1'b0;
            if (raw != prev) begin
                prev  = raw;
                quiet = '0;
            end
            else if (quiet != '1) begin
                quiet = quiet + 1'b1;
            end
            if (quiet >= debounce_ticks && stable != raw) begin
                fell   = stable && !raw;
                stable = raw;
            end
            return fell;
        endfunction

        // Advance one tick and queue the levels it must produce
        function void take_tick(bit cyc, bit rst);
            led_levels_t due;
            int unsigned sum;
            if (blink_elapsed != '1)
                blink_elapsed = blink_elapsed + 1'b1;
            if (fade_elapsed != '1)
                fade_elapsed = fade_elapsed + 1'b1;

            if (debounce(cyc, cyc_prev, cyc_quiet, cyc_stable)) begin
                mode = mode_t'(2'(mode + 2'd1));
                clear_effects();
            end
            // reset press applied last so it wins over a same-tick cycle press
            if (debounce(rst, rst_prev, rst_quiet, rst_stable)) begin
                mode = MODE_OFF;
                set_all(8'h00);
                clear_effects();
            end

            case (mode)
                MODE_OFF: set_all(8'h00);
                MODE_ON:  set_all(8'hFF);
                MODE_BLINK:
                begin
                    if (blink_elapsed >= blink_ticks) begin
                        blink_phase   = !blink_phase;
                        blink_elapsed = '0;
                    end
                    levels[0] = blink_phase ? 8'hFF : 8'h00;
                    levels[1] = blink_phase ? 8'h00 : 8'hFF;
                    levels[2] = blink_phase ? 8'hFF : 8'h00;
                end
                default:
                begin
                    // levels of the previous mode stay until the first fade step
                    if (fade_elapsed >= fade_ticks) begin
                        if (fade_rising) begin
                            sum = fade_value + fade_step;
                            if (sum >= LEVEL_FULL) begin
                                fade_value  = LEVEL_FULL;
                                fade_rising = 1'b0;
                            end
                            else if (sum == 0) begin
                                fade_value  = 0;
                                fade_rising = 1'b1;
                            end
                            else begin
                                fade_value = sum;
                            end
                        end
                        else if (fade_value <= fade_step) begin
                            fade_value  = 0;
                            fade_rising = 1'b1;
                        end
                        else begin
                            fade_value = fade_value - fade_step;
                            if (fade_value >= LEVEL_FULL) begin
                                fade_value  = LEVEL_FULL;
                                fade_rising = 1'b0;
                            end
                        end
                        set_all(fade_value[7:0]);
                        fade_elapsed = '0;
                    end
                end
            endcase

            due        = '0;
            due.mode   = mode;
            due.yellow = levels[0];
            due.green  = levels[1];
            due.red    = levels[2];
            levels_due.push_back(due);
        endfunction

        function void flag_field(string name, logic [7:0] want, logic [7:0] got);
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        endfunction

        // Compare one result with the oldest owed levels
        function void match_levels(logic [OUT_BITS-1:0] data);
            led_levels_t got;
            led_levels_t want;
            got = data;
            if (levels_due.size() == 0) begin
                errors++;
                $display("%0t: result %h with nothing expected", $time, data);
                return;
            end
            want = levels_due.pop_front();
            if (got.yellow !== want.yellow)
                flag_field("yellow", want.yellow, got.yellow);
            if (got.green !== want.green)
                flag_field("green", want.green, got.green);
            if (got.red !== want.red)
                flag_field("red", want.red, got.red);
            if (got.mode !== want.mode)
                flag_field("mode", 8'(want.mode), 8'(got.mode));
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_BITS-1:0]     m_axis_tdata;
    logic                    cfg_wen;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_wdata;

    led_mode_tracker tracker;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    bit              hold_request   = 1'b0;
    int              hold_left      = 0;
    int              cycle_count    = 0;
    int              cur_debounce   = 0;

    led_mode_sequencer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** led_mode_sequencer_top: FAILED **");
        $finish;
    end

    // Check results; stall at random or hold off for a long stretch on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                tracker.match_levels(m_axis_tdata);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one tick request, idling at random first; return on the edge that takes it
    task automatic send_tick(input bit cyc, input bit rst);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, rst, cyc};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.take_tick(cyc, rst);
    endtask

    // Drop valid and wait until every owed result has come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (tracker.levels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all four registers while the block is idle
    task automatic apply_settings(input logic [CFG_BITS-1:0] deb, input logic [CFG_BITS-1:0] blink,
                                  input logic [CFG_BITS-1:0] fade, input logic [STEP_BITS-1:0] step);
        logic [CFG_IDX_BITS-1:0] idx[4];
        logic [CFG_BITS-1:0]     val[4];
        idx = '{CFG_DEBOUNCE_TICKS, CFG_BLINK_TICKS, CFG_FADE_TICKS, CFG_FADE_STEP};
        val = '{deb, blink, fade, {8'h00, step}};
        drain_results();
        for (int i = 0; i < 4; i++) begin
            cfg_wen   <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge clk);
            tracker.write_register(idx[i], val[i]);
        end
        cfg_wen <= 1'b0;
        cur_debounce = int'(deb);
    endtask

    task automatic set_idling(input int kind);
        case (kind)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
        endcase
    endtask

    // Mostly full presses held past the debounce time, some cut short, some noise
    task automatic run_random(input int count, input bit with_hold);
        int sent;
        int choice;
        int span;
        int press_len;
        int gap_len;
        int quiet_len;
        bit cyc;
        bit rst;
        sent = 0;
        span = (cur_debounce > 40) ? 40 : cur_debounce;
        while (sent < count) begin
            choice    = int'($urandom_range(99));
            press_len = ($urandom_range(4) == 0) ? int'($urandom_range(span))
                                                 : span + int'($urandom_range(1, 3));
            gap_len   = span + int'($urandom_range(1, 4));
            if (choice < 70) begin
                cyc = !(choice < 50 || choice >= 62);
                rst = (choice < 50);
                repeat (press_len) send_tick(cyc, rst);
                repeat (gap_len) send_tick(1'b1, 1'b1);
                sent += press_len + gap_len;
            end
            else if (choice < 85) begin
                quiet_len = int'($urandom_range(1, 20));
                repeat (quiet_len) send_tick(1'b1, 1'b1);
                sent += quiet_len;
            end
            else begin
                quiet_len = int'($urandom_range(1, 6));
                repeat (quiet_len) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                sent += quiet_len;
            end
            // stall the output long enough to back up the input
            if (with_hold && sent >= count / 2) begin
                hold_request = 1'b1;
                with_hold    = 1'b0;
            end
        end
    endtask

    initial
    begin
        tracker       = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        cfg_wen       = 1'b0;
        cfg_index     = CFG_DEBOUNCE_TICKS;
        cfg_wdata     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: a short press is filtered out
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);

        // Zero debounce, one-tick intervals, full fade step
        apply_settings(16'd0, 16'd1, 16'd1, 8'd255);
        send_tick(1'b0, 1'b1);                           // all on
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);                           // blink, phase low
        send_tick(1'b0, 1'b1);                           // blink toggles
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);                           // fade keeps blink levels
        send_tick(1'b0, 1'b1);                           // fade clamps at full
        send_tick(1'b0, 1'b1);                           // fade clamps at zero
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);                           // mode wraps to off
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);                           // reset press forces off
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);                           // both pressed: reset wins
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);

        // Random phases over a range of settings and idling patterns
        for (int p = 0; p < PHASES; p++) begin
            set_idling(p % 4);
            case (p)
                0: apply_settings(16'd0, 16'd0, 16'd0, 8'd0);
                1: apply_settings(16'd1, 16'd1, 16'd1, 8'd255);
                2: apply_settings(16'd2, 16'd3, 16'd2, 8'd7);
                3: apply_settings(16'd3, 16'd5, 16'd1, 8'd51);
                4: apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 8'd1);
                5: apply_settings(16'hFFFF, 16'd2, 16'd2, 8'd128);
                6: apply_settings(CFG_BITS'($urandom_range(4)), CFG_BITS'($urandom_range(1, 8)),
                                  CFG_BITS'($urandom_range(1, 6)),
                                  STEP_BITS'($urandom_range(1, 255)));
                default: apply_settings(DEBOUNCE_TICKS_RST, BLINK_TICKS_RST,
                                        FADE_TICKS_RST, FADE_STEP_RST);
            endcase
            run_random((p == 5) ? 40 : 66, p == 4);
        end

        drain_results();
        if (tracker.errors == 0)
            $display("** led_mode_sequencer_top: PASSED **");
        else
            $display("** led_mode_sequencer_top: FAILED **");
        $finish;
    end

endmodule

/* files.f */
hdl/lms_pkg.sv
hdl/lms_debounce.sv
hdl/led_mode_sequencer_top.sv
test/led_mode_sequencer_top_test.sv
